// File: rtl/row_range_sorted_query_unit_macros.svh
// Assertion macros for the row range sorted query unit.
// Depends on clk and arst_n being visible at the place of use.
`ifndef ROW_RANGE_SORTED_QUERY_UNIT_MACROS_SVH
`define ROW_RANGE_SORTED_QUERY_UNIT_MACROS_SVH

// same-cycle implication, quiet during reset
`define RRSQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, quiet during reset
`define RRSQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/rrsq_pkg.sv
// Shared types and constants for the row range sorted query unit.
// No dependencies.
package rrsq_pkg;

	localparam int MAX_ROWS   = 1024;
	localparam int MAX_COLS   = 64;
	localparam int VALUE_BITS = 32;

	localparam int ROW_AW  = $clog2(MAX_ROWS);
	localparam int COL_AW  = $clog2(MAX_COLS);
	localparam int ROWS_W  = 11;
	localparam int COLS_W  = 7;
	localparam int CFG_W   = 11;
	localparam int CFG_IW  = 1;

	typedef enum logic [CFG_IW-1:0] {
		REG_NUM_ROWS = 1'b0,
		REG_NUM_COLS = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		OP_CELL  = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef struct packed {
		op_t                     op;
		logic signed [VALUE_BITS-1:0] cell_value;
		logic [ROWS_W-1:0]       first_row;
		logic [ROWS_W-1:0]       last_row;
	} in_item_t;

	typedef struct packed {
		logic is_sorted;
		logic range_error;
	} res_item_t;

	function automatic logic [VALUE_BITS-1:0] order_key(input logic [VALUE_BITS-1:0] raw);
		order_key = raw ^ {1'b1, {(VALUE_BITS-1){1'b0}}};
	endfunction

endpackage

// File: rtl/row_range_sorted_query_unit.sv
// A query's result is registered through query_s1 and then result_valid_q; cells give no result.
// Throughput: one transaction per cycle, cell or query; busy stays low.
// Column compare and descent-row lookup each use one registered-read RAM port.
// Reset clears counters, config (num_rows = num_cols = 1) and pipeline valids;
// row and descent memories are not cleared. The receiver cannot stall.
`include "row_range_sorted_query_unit_macros.svh"

module row_range_sorted_query_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  rrsq_pkg::in_item_t           item,
	input  logic                         cfg_we,
	input  logic [rrsq_pkg::CFG_IW-1:0]  cfg_index,
	input  logic [rrsq_pkg::CFG_W-1:0]   cfg_data,
	output logic                         result_valid,
	output rrsq_pkg::res_item_t          result
);
	import rrsq_pkg::*;

	logic [ROWS_W-1:0]     num_rows_q;
	logic [COLS_W-1:0]     num_cols_q;
	logic [ROWS_W-1:0]     row_cnt_q;
	logic [COL_AW-1:0]     col_cnt_q;
	logic [ROW_AW-1:0]     running_q;

	logic [ROWS_W-1:0]     rows_eff;
	logic [COLS_W-1:0]     cols_eff;
	logic                  acc;
	logic                  cell_take;
	logic                  query_take;
	logic                  row_end;
	logic [VALUE_BITS-1:0] key_in;
	logic [ROW_AW-1:0]     q_addr;
	logic                  q_err;

	logic                  cell_s1;
	logic [COL_AW-1:0]     col_s1;
	logic [ROW_AW-1:0]     row_s1;
	logic [VALUE_BITS-1:0] key_s1;
	logic                  has_prev_s1;
	logic                  row_end_s1;
	logic                  fwd_prev_s1;
	logic [VALUE_BITS-1:0] fwd_key_s1;
	logic                  query_s1;
	logic                  err_s1;
	logic                  trivial_s1;
	logic [ROWS_W-1:0]     first_s1;
	logic                  fwd_ldr_s1;
	logic [ROW_AW-1:0]     fwd_ldr_s1_val;

	logic [VALUE_BITS-1:0] prev_rdata;
	logic [ROW_AW-1:0]     ldr_rdata;
	logic [VALUE_BITS-1:0] prev_val;
	logic                  descent;
	logic [ROW_AW-1:0]     new_running;
	logic                  ldr_we;
	logic [ROW_AW-1:0]     ldr_val;
	logic                  sorted;

	logic                  result_valid_q;
	res_item_t             result_q;

	assign busy       = 1'b0;
	assign acc        = start && !busy;
	assign rows_eff   = (num_rows_q > ROWS_W'(MAX_ROWS)) ? ROWS_W'(MAX_ROWS) : num_rows_q;
	assign cols_eff   = (num_cols_q > COLS_W'(MAX_COLS)) ? COLS_W'(MAX_COLS) : num_cols_q;
	assign cell_take  = acc && (item.op == OP_CELL) && (cols_eff != '0) && (row_cnt_q < rows_eff);
	assign query_take = acc && (item.op == OP_QUERY);
	assign row_end    = ({1'b0, col_cnt_q} + COLS_W'(1)) >= cols_eff;
	assign key_in     = order_key(item.cell_value);
	assign q_addr     = ROW_AW'(item.last_row - ROWS_W'(1));
	assign q_err      = (item.last_row == '0) || (item.last_row > row_cnt_q)
		|| (item.last_row > num_rows_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q <= ROWS_W'(1);
			num_cols_q <= COLS_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NUM_ROWS: num_rows_q <= cfg_data;
				REG_NUM_COLS: num_cols_q <= cfg_data[COLS_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_cnt_q <= '0;
			col_cnt_q <= '0;
		end else if (cell_take) begin
			if (row_end) begin
				row_cnt_q <= row_cnt_q + ROWS_W'(1);
				col_cnt_q <= '0;
			end else begin
				col_cnt_q <= col_cnt_q + COL_AW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_s1  <= 1'b0;
			query_s1 <= 1'b0;
		end else begin
			cell_s1  <= cell_take;
			query_s1 <= query_take;
		end
	end

	always_ff @(posedge clk) begin
		col_s1         <= col_cnt_q;
		row_s1         <= row_cnt_q[ROW_AW-1:0];
		key_s1         <= key_in;
		has_prev_s1    <= row_cnt_q != '0;
		row_end_s1     <= row_end;
		fwd_prev_s1    <= cell_s1 && (col_s1 == col_cnt_q);
		fwd_key_s1     <= key_s1;
		err_s1         <= q_err;
		trivial_s1     <= item.first_row >= item.last_row;
		first_s1       <= item.first_row;
		fwd_ldr_s1     <= ldr_we && (row_s1 == q_addr);
		fwd_ldr_s1_val <= new_running;
	end

	rrsq_ram #(
		.WIDTH(VALUE_BITS),
		.DEPTH(MAX_COLS)
	) u_prev_ram (
		.clk  (clk),
		.we   (cell_s1),
		.waddr(col_s1),
		.wdata(key_s1),
		.re   (cell_take),
		.raddr(col_cnt_q),
		.rdata(prev_rdata)
	);

	assign prev_val    = fwd_prev_s1 ? fwd_key_s1 : prev_rdata;
	assign descent     = cell_s1 && has_prev_s1 && (prev_val > key_s1);
	assign new_running = descent ? row_s1 : running_q;
	assign ldr_we      = cell_s1 && row_end_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= '0;
		end else if (cell_s1) begin
			running_q <= new_running;
		end
	end

	rrsq_ram #(
		.WIDTH(ROW_AW),
		.DEPTH(MAX_ROWS)
	) u_ldr_ram (
		.clk  (clk),
		.we   (ldr_we),
		.waddr(row_s1),
		.wdata(new_running),
		.re   (query_take),
		.raddr(q_addr),
		.rdata(ldr_rdata)
	);

	assign ldr_val = fwd_ldr_s1 ? fwd_ldr_s1_val : ldr_rdata;
	assign sorted  = !err_s1 && (trivial_s1 || (({1'b0, ldr_val} + ROWS_W'(1)) <= first_s1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= query_s1;
		end
	end

	always_ff @(posedge clk) begin
		result_q.is_sorted   <= sorted;
		result_q.range_error <= err_s1;
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`RRSQ_ASSERT_NEXT(a_query_answered, query_s1, result_valid, "query transaction lost")
	`RRSQ_ASSERT_NOW(a_error_not_sorted, result_valid && result.range_error, !result.is_sorted, "error result marked sorted")
	`RRSQ_ASSERT_NOW(a_rows_bounded, 1'b1, row_cnt_q <= ROWS_W'(MAX_ROWS), "row count beyond table")

endmodule

// File: rtl/rrsq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rrsq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: bench/tb.sv
// Testbench for row_range_sorted_query_unit: loads one table cell by cell, issues
// range queries and checks each answer against an in-bench copy of the descent tracking.
// Depends on rrsq_pkg and the row_range_sorted_query_unit RTL.
module tb;
	import rrsq_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 6;
	localparam int RANDOM_ITEMS   = 120;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	in_item_t          item = '0;
	logic              cfg_we = 1'b0;
	logic [CFG_IW-1:0] cfg_index = '0;
	logic [CFG_W-1:0]  cfg_data = '0;
	logic              result_valid;
	res_item_t         result;

	row_range_sorted_query_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result       (result)
	);

	// table tracking state
	logic [ROWS_W-1:0]            num_rows_cfg = 11'd1;
	logic [COLS_W-1:0]            num_cols_cfg = 7'd1;
	logic signed [VALUE_BITS-1:0] row_above [MAX_COLS];
	logic [ROW_AW-1:0]            descent_row_of [MAX_ROWS];
	int unsigned                  rows_loaded = 0;
	int unsigned                  col_pos = 0;
	logic [ROW_AW-1:0]            newest_descent = '0;

	res_item_t answers_due [$];
	in_item_t  pending_items [$];

	int  gap_left = 0;
	bit  gap_mode = 1'b0;
	int  level = 100;
	int  quiet_cycles = 0;
	int  n_accepted = 0;
	int  n_queries = 0;
	int  n_answers = 0;
	int  n_cfg_writes = 0;
	int  mismatches = 0;

	function automatic void absorb_value(input logic signed [VALUE_BITS-1:0] value);
		int unsigned row_cap, col_cap;
		row_cap = (num_rows_cfg < MAX_ROWS) ? num_rows_cfg : MAX_ROWS;
		col_cap = (num_cols_cfg < MAX_COLS) ? num_cols_cfg : MAX_COLS;
		if (col_cap == 0 || rows_loaded >= row_cap || col_pos >= MAX_COLS)
			return;
		if (rows_loaded > 0 && row_above[col_pos] > value)
			newest_descent = ROW_AW'(rows_loaded);
		row_above[col_pos] = value;
		if (col_pos + 1 >= col_cap) begin
			descent_row_of[rows_loaded] = newest_descent;
			rows_loaded++;
			col_pos = 0;
		end else begin
			col_pos++;
		end
	endfunction

	function automatic res_item_t answer_query(input logic [ROWS_W-1:0] first_r,
			input logic [ROWS_W-1:0] last_r);
		res_item_t ans;
		ans = '0;
		if (last_r == 0 || last_r > rows_loaded || last_r > num_rows_cfg)
			ans.range_error = 1'b1;
		else if (first_r >= last_r)
			ans.is_sorted = 1'b1;
		else
			ans.is_sorted = (int'(descent_row_of[last_r - 1]) + 1 <= int'(first_r));
		return ans;
	endfunction

	function automatic in_item_t value_item(input logic signed [VALUE_BITS-1:0] v);
		in_item_t it;
		it.op = OP_CELL;
		it.cell_value = v;
		it.first_row = ROWS_W'($urandom);
		it.last_row = ROWS_W'($urandom);
		return it;
	endfunction

	function automatic in_item_t query_item(input int f, input int l);
		in_item_t it;
		it.op = OP_QUERY;
		it.cell_value = VALUE_BITS'($urandom);
		it.first_row = ROWS_W'(f);
		it.last_row = ROWS_W'(l);
		return it;
	endfunction

	// mostly rising values so that sorted ranges are common
	function automatic logic signed [VALUE_BITS-1:0] next_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 3)
			return VALUE_BITS'($urandom);
		if (r < 7)
			level -= $urandom_range(1, 5000);
		else
			level += $urandom_range(0, 3);
		return level;
	endfunction

	function automatic in_item_t random_query(input int est);
		int r, f, l, span;
		r = $urandom_range(0, 99);
		if (est < 1)
			est = 1;
		if (r < 8) begin
			f = $urandom_range(0, 2047);
			l = $urandom_range(0, 2047);
		end else if (r < 14) begin
			l = est + $urandom_range(0, 3);
			f = $urandom_range(0, l);
		end else begin
			l = $urandom_range(1, est);
			span = $urandom_range(0, 99);
			if (span < 50)
				f = l - $urandom_range(1, (l < 40) ? l : 40);
			else if (span < 62)
				f = l + $urandom_range(0, 5);
			else if (span < 72)
				f = 0;
			else
				f = $urandom_range(0, l);
		end
		return query_item(f, l);
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!gap_mode || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_NUM_ROWS)
			num_rows_cfg = data[ROWS_W-1:0];
		else
			num_cols_cfg = data[COLS_W-1:0];
		n_cfg_writes++;
	endtask

	// hold until every transaction is in and every answer is back
	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_items.size() != 0 || start || answers_due.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				n_accepted++;
				if (item.op == OP_QUERY) begin
					answers_due.push_back(answer_query(item.first_row, item.last_row));
					n_queries++;
				end else begin
					absorb_value(item.cell_value);
				end
			end
			if (!(start && busy)) begin
				if (gap_left > 0) begin
					start <= 1'b0;
					gap_left--;
				end else if (pending_items.size() > 0) begin
					item <= pending_items.pop_front();
					start <= 1'b1;
					gap_left = pick_gap();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor and watchdog
	always @(posedge clk) begin
		res_item_t want;
		if (arst_n) begin
			if (result_valid) begin
				n_answers++;
				if (answers_due.size() == 0) begin
					$display("%0t: unexpected answer is_sorted=%0b range_error=%0b",
						$time, result.is_sorted, result.range_error);
					mismatches++;
				end else begin
					want = answers_due.pop_front();
					if (result.is_sorted !== want.is_sorted) begin
						$display("%0t: is_sorted expected %0b actual %0b",
							$time, want.is_sorted, result.is_sorted);
						mismatches++;
					end
					if (result.range_error !== want.range_error) begin
						$display("%0t: range_error expected %0b actual %0b",
							$time, want.range_error, result.range_error);
						mismatches++;
					end
				end
			end
			if ((start && !busy) || result_valid || cfg_we)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: watchdog expired, %0d answers outstanding",
					$time, answers_due.size());
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// stimulus
	initial begin
		int random_items, pick, cols, eff_cols, junk, n, cells, est, need;
		random_items = 0;
		wait (arst_n);
		@(negedge clk);

		// queries before anything is loaded
		pending_items.push_back(query_item(0, 0));
		pending_items.push_back(query_item(1, 1));
		wait_idle();

		// full-width first row writes every column
		write_reg(REG_NUM_ROWS, 11'd1024);
		write_reg(REG_NUM_COLS, 11'd64);
		@(negedge clk);
		for (int c = 0; c < MAX_COLS; c++)
			pending_items.push_back(value_item(c == 0 ? 32'sh8000_0000 :
				c == 1 ? 32'sh7fff_ffff : VALUE_BITS'($urandom)));
		pending_items.push_back(query_item(1, 1));
		pending_items.push_back(query_item(0, 1));
		wait_idle();

		// descent from max to min, then a clean row
		write_reg(REG_NUM_COLS, 11'd2);
		@(negedge clk);
		pending_items.push_back(value_item(32'sh8000_0000));
		pending_items.push_back(value_item(32'sh8000_0000));
		pending_items.push_back(value_item(32'sh8000_0000));
		pending_items.push_back(value_item(32'sd5));
		pending_items.push_back(query_item(2, 3));
		pending_items.push_back(query_item(1, 3));
		pending_items.push_back(query_item(3, 3));
		pending_items.push_back(query_item(2047, 3));
		pending_items.push_back(query_item(1, 2047));
		pending_items.push_back(query_item(1, 1024));
		wait_idle();

		// zero columns drop cells; oversize column count saturates
		write_reg(REG_NUM_COLS, 11'd0);
		@(negedge clk);
		repeat (3) pending_items.push_back(value_item(VALUE_BITS'($urandom)));
		pending_items.push_back(query_item(1, 4));
		wait_idle();
		write_reg(REG_NUM_COLS, 11'd127);
		@(negedge clk);
		repeat (MAX_COLS) pending_items.push_back(value_item(next_value()));
		pending_items.push_back(query_item(3, 4));
		wait_idle();

		// shrink the column count in the middle of a row
		write_reg(REG_NUM_COLS, 11'd4);
		@(negedge clk);
		repeat (2) pending_items.push_back(value_item(next_value()));
		wait_idle();
		write_reg(REG_NUM_COLS, 11'd1);
		@(negedge clk);
		pending_items.push_back(value_item(next_value()));
		pending_items.push_back(query_item(4, 5));
		pending_items.push_back(query_item(0, 5));
		wait_idle();

		// table limit below the loaded rows
		write_reg(REG_NUM_ROWS, 11'd1);
		@(negedge clk);
		pending_items.push_back(value_item(next_value()));
		pending_items.push_back(query_item(1, 2));
		pending_items.push_back(query_item(0, 1));
		pending_items.push_back(query_item(1, 1));
		wait_idle();
		write_reg(REG_NUM_ROWS, 11'd2047);

		while (random_items < RANDOM_ITEMS) begin
			wait_idle();
			pick = $urandom_range(0, 99);
			if (pick < 60)
				cols = 1;
			else if (pick < 82)
				cols = 2;
			else if (pick < 92)
				cols = $urandom_range(3, 8);
			else if (pick < 95)
				cols = 64;
			else if (pick < 98)
				cols = $urandom_range(65, 127);
			else
				cols = 0;
			junk = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
			write_reg(REG_NUM_COLS, {4'(junk), 7'(cols)});
			pick = $urandom_range(0, 99);
			if (pick < 20)
				write_reg(REG_NUM_ROWS, CFG_W'($urandom_range(1, 2047)));
			else if (pick < 35)
				write_reg(REG_NUM_ROWS, 11'd1024);
			@(negedge clk);
			gap_mode = ($urandom_range(0, 3) != 0);
			eff_cols = (cols > MAX_COLS) ? MAX_COLS : cols;
			n = $urandom_range(10, 60);
			cells = 0;
			for (int i = 0; i < n; i++) begin
				est = rows_loaded + ((eff_cols != 0) ? cells / eff_cols : 0);
				if (est > MAX_ROWS)
					est = MAX_ROWS;
				if ($urandom_range(0, 99) < 78) begin
					pending_items.push_back(value_item(next_value()));
					cells++;
				end else begin
					pending_items.push_back(random_query(est));
				end
				random_items++;
			end
		end

		// fill the table to its largest size, then run past the end
		wait_idle();
		write_reg(REG_NUM_ROWS, 11'd1024);
		write_reg(REG_NUM_COLS, 11'd1);
		@(negedge clk);
		gap_mode = 1'b1;
		need = MAX_ROWS - rows_loaded + 4;
		for (int i = 0; i < need; i++) begin
			pending_items.push_back(value_item(next_value()));
			if ($urandom_range(0, 19) == 0)
				pending_items.push_back(random_query(rows_loaded + i));
		end
		pending_items.push_back(query_item(1023, 1024));
		pending_items.push_back(query_item(0, 1024));
		pending_items.push_back(query_item(1024, 1024));
		pending_items.push_back(query_item(1, 1024));
		pending_items.push_back(query_item(1, 1025));
		pending_items.push_back(query_item(1024, 2047));
		repeat (20) pending_items.push_back(random_query(MAX_ROWS));
		wait_idle();
		repeat (8) @(posedge clk);

		if (answers_due.size() != 0) begin
			$display("%0t: %0d answers never arrived", $time, answers_due.size());
			mismatches++;
		end
		$display("Loaded %0d table rows and checked %0d answers to %0d queries",
			rows_loaded, n_answers, n_queries);
		$display("across %0d transactions and %0d register writes; %0d mismatches",
			n_accepted, n_cfg_writes, mismatches);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
